[hdl/huffman_delta_byte_decoder_defines.svh]
// Assertion macros shared by the checker of the Huffman delta byte decoder.
`ifndef HUFFMAN_DELTA_BYTE_DECODER_DEFINES_SVH
`define HUFFMAN_DELTA_BYTE_DECODER_DEFINES_SVH

// Condition holds in this cycle, property checked in the same cycle.
`define HDB_ASSERT_NOW(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Condition holds in this cycle, property checked in the next cycle.
`define HDB_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

[hdl/hdb_pkg.sv]
// Package with the constants, codes and control structs of the decoder.
package hdb_pkg;

  localparam int SYMBOLS      = 256;
  localparam int NODE_W       = 10;
  localparam int COUNT_W      = 16;
  localparam int LIMIT_W      = 24;
  localparam int CHILD_W      = 2 * NODE_W;
  localparam int WEIGHT_DEPTH = 2 * SYMBOLS + 2;
  localparam int CHILD_DEPTH  = SYMBOLS;
  localparam int CHILD_AW     = $clog2(CHILD_DEPTH);
  localparam int WEIGHT_AW    = $clog2(WEIGHT_DEPTH);

  localparam logic [NODE_W-1:0] END_NODE    = NODE_W'(SYMBOLS);
  localparam logic [NODE_W-1:0] FIRST_INNER = NODE_W'(SYMBOLS + 1);
  localparam logic [NODE_W-1:0] TOP_NODE    = NODE_W'(2 * SYMBOLS);
  localparam logic [NODE_W-1:0] LAST_HEADER = NODE_W'(2 * SYMBOLS - 1);

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 24'd39758;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [1:0] PH_HEADER   = 2'd0;
  localparam logic [1:0] PH_DATA     = 2'd1;
  localparam logic [1:0] PH_FINISHED = 2'd2;

  typedef struct packed {
    logic       capture;
    logic       head_hi;
    logic       head_wr;
    logic       hidx_inc;
    logic       hidx_clr;
    logic       build_init;
    logic       scan_init;
    logic       scan_issue;
    logic       merge_wr;
    logic       zero_m1;
    logic       zero_m2;
    logic       merge_next;
    logic       data_start;
    logic       bit_load;
    logic       bit_dec;
    logic       walk_child;
    logic       emit_data;
    logic       record;
    logic [1:0] rec_kind;
    logic       flush;
  } cmd_t;

  typedef struct packed {
    logic hidx_odd;
    logic hidx_last;
    logic in_last;
    logic emit_ge;
    logic emit_next_ge;
    logic walk_bad;
    logic child_ge_walk;
    logic child_inner;
    logic child_end;
    logic bit_zero;
    logic scan_at_end;
    logic have_two;
    logic fresh_top;
    logic rec_ok;
    logic pend_valid;
    logic out_free;
  } sts_t;

endpackage

[hdl/hdb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module hdb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/hdb_ctrl.sv]
// Controller state machine: sequences header, tree build and code walk.
module hdb_ctrl (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_valid,
  output logic         s_ready,
  input  hdb_pkg::sts_t sts,
  output hdb_pkg::cmd_t cmd
);
  import hdb_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_HEAD     = 4'd1;
  localparam logic [3:0] S_BINIT    = 4'd2;
  localparam logic [3:0] S_SCANINIT = 4'd3;
  localparam logic [3:0] S_SCAN     = 4'd4;
  localparam logic [3:0] S_SCANLAST = 4'd5;
  localparam logic [3:0] S_MERGE0   = 4'd6;
  localparam logic [3:0] S_MERGE1   = 4'd7;
  localparam logic [3:0] S_MERGE2   = 4'd8;
  localparam logic [3:0] S_BDONE    = 4'd9;
  localparam logic [3:0] S_DCHK     = 4'd10;
  localparam logic [3:0] S_WRD      = 4'd11;
  localparam logic [3:0] S_WEV      = 4'd12;
  localparam logic [3:0] S_STOP     = 4'd13;
  localparam logic [3:0] S_FLUSH    = 4'd14;
  localparam logic [3:0] S_FIN      = 4'd15;

  logic [3:0] state, state_next;
  logic [1:0] phase, phase_next;
  logic [1:0] stop_kind, stop_kind_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_HEADER;
      stop_kind <= KIND_ERROR;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      stop_kind <= stop_kind_next;
    end
  end

  assign s_ready = (state == S_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.rec_kind   = KIND_DATA;
    state_next     = state;
    phase_next     = phase;
    stop_kind_next = stop_kind;
    unique case (state)
      S_IDLE: begin
        if (s_valid) begin
          cmd.capture = 1'b1;
          priority if (phase == PH_HEADER) state_next = S_HEAD;
          else if (phase == PH_DATA) state_next = S_DCHK;
          else state_next = S_FIN;
        end
      end
      S_HEAD: begin
        cmd.head_hi  = !sts.hidx_odd;
        cmd.head_wr  = sts.hidx_odd;
        cmd.hidx_inc = 1'b1;
        priority if (sts.in_last) begin
          stop_kind_next = KIND_ERROR;
          state_next     = S_STOP;
        end else if (sts.hidx_last) begin
          state_next = S_BINIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_BINIT: begin
        cmd.build_init = 1'b1;
        state_next     = S_SCANINIT;
      end
      S_SCANINIT: begin
        cmd.scan_init = 1'b1;
        state_next    = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (sts.scan_at_end) state_next = S_SCANLAST;
      end
      S_SCANLAST: begin
        state_next = S_MERGE0;
      end
      S_MERGE0: begin
        if (sts.have_two) begin
          cmd.merge_wr = 1'b1;
          state_next   = S_MERGE1;
        end else begin
          state_next = S_BDONE;
        end
      end
      S_MERGE1: begin
        cmd.zero_m1 = 1'b1;
        state_next  = S_MERGE2;
      end
      S_MERGE2: begin
        cmd.zero_m2    = 1'b1;
        cmd.merge_next = 1'b1;
        state_next     = sts.fresh_top ? S_BDONE : S_SCANINIT;
      end
      S_BDONE: begin
        cmd.data_start = 1'b1;
        cmd.hidx_clr   = 1'b1;
        phase_next     = PH_DATA;
        state_next     = S_IDLE;
      end
      S_DCHK: begin
        if (sts.emit_ge) begin
          stop_kind_next = KIND_DONE;
          state_next     = S_STOP;
        end else begin
          cmd.bit_load = 1'b1;
          state_next   = S_WRD;
        end
      end
      S_WRD: begin
        if (sts.walk_bad) begin
          stop_kind_next = KIND_ERROR;
          state_next     = S_STOP;
        end else begin
          state_next = S_WEV;
        end
      end
      S_WEV: begin
        priority if (sts.child_ge_walk) begin
          stop_kind_next = KIND_ERROR;
          state_next     = S_STOP;
        end else if (sts.child_end) begin
          stop_kind_next = KIND_DONE;
          state_next     = S_STOP;
        end else if (sts.child_inner || sts.rec_ok) begin
          cmd.walk_child = sts.child_inner;
          cmd.emit_data  = !sts.child_inner;
          cmd.record     = !sts.child_inner;
          if (!sts.child_inner && sts.emit_next_ge) begin
            stop_kind_next = KIND_DONE;
            state_next     = S_STOP;
          end else if (sts.bit_zero) begin
            if (sts.in_last) begin
              stop_kind_next = KIND_ERROR;
              state_next     = S_STOP;
            end else begin
              state_next = S_FLUSH;
            end
          end else begin
            cmd.bit_dec = 1'b1;
            state_next  = S_WRD;
          end
        end
      end
      S_STOP: begin
        if (sts.rec_ok) begin
          cmd.record   = 1'b1;
          cmd.rec_kind = stop_kind;
          cmd.hidx_clr = 1'b1;
          phase_next   = sts.in_last ? PH_HEADER : PH_FINISHED;
          state_next   = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!sts.pend_valid) begin
          state_next = S_IDLE;
        end else if (sts.out_free) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_FIN: begin
        if (sts.in_last) begin
          phase_next   = PH_HEADER;
          cmd.hidx_clr = 1'b1;
        end
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[hdl/hdb_dp.sv]
// Datapath: weight and child stores, merge search, code walk and result staging.
module hdb_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  hdb_pkg::cmd_t               cmd,
  output hdb_pkg::sts_t               sts,
  input  logic [7:0]                  in_byte,
  input  logic                        in_last,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_byte,
  output logic [1:0]                  out_kind,
  output logic                        out_last,
  input  logic                        cfg_we,
  input  logic [hdb_pkg::LIMIT_W-1:0] cfg_wdata
);
  import hdb_pkg::*;

  logic [7:0]         byte_q, hi_byte, prev;
  logic               last_q;
  logic [NODE_W-1:0]  hidx, root, walk, fresh, scan_idx, pipe_addr, m1, m2;
  logic               pipe_v, v1, v2;
  logic [COUNT_W-1:0] w1, w2;
  logic [2:0]         bit_idx;
  logic [LIMIT_W-1:0] emitted, limit, emitted_inc;
  logic               pend_valid;
  logic [7:0]         pend_byte;
  logic [1:0]         pend_kind;

  logic                 w_we;
  logic [WEIGHT_AW-1:0] w_waddr;
  logic [COUNT_W-1:0]   w_wdata, w_rdata;
  logic [COUNT_W-1:0]   wsum;
  logic [CHILD_W-1:0]   c_rdata;
  logic [NODE_W-1:0]    walk_off, fresh_off, child;
  logic [7:0]           data_byte, rec_byte;
  logic                 out_free, push;

  // The merged count wraps at the count width.
  assign wsum      = w1 + w2;
  assign walk_off  = walk - FIRST_INNER;
  assign fresh_off = fresh - FIRST_INNER;

  always_comb begin
    w_we    = 1'b0;
    w_waddr = '0;
    w_wdata = '0;
    priority if (cmd.head_wr) begin
      w_we    = 1'b1;
      w_waddr = WEIGHT_AW'(hidx >> 1);
      w_wdata = {hi_byte, byte_q};
    end else if (cmd.build_init) begin
      w_we    = 1'b1;
      w_waddr = WEIGHT_AW'(END_NODE);
      w_wdata = COUNT_W'(1);
    end else if (cmd.merge_wr) begin
      w_we    = 1'b1;
      w_waddr = WEIGHT_AW'(fresh);
      w_wdata = wsum;
    end else if (cmd.zero_m1) begin
      w_we    = 1'b1;
      w_waddr = WEIGHT_AW'(m1);
    end else if (cmd.zero_m2) begin
      w_we    = 1'b1;
      w_waddr = WEIGHT_AW'(m2);
    end
  end

  hdb_ram #(.WIDTH(COUNT_W), .DEPTH(WEIGHT_DEPTH)) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (WEIGHT_AW'(scan_idx)),
    .rdata (w_rdata)
  );

  hdb_ram #(.WIDTH(CHILD_W), .DEPTH(CHILD_DEPTH)) u_child_ram (
    .clk   (clk),
    .we    (cmd.merge_wr),
    .waddr (fresh_off[CHILD_AW-1:0]),
    .wdata ({m2, m1}),
    .raddr (walk_off[CHILD_AW-1:0]),
    .rdata (c_rdata)
  );

  assign child       = byte_q[bit_idx] ? c_rdata[CHILD_W-1:NODE_W] : c_rdata[NODE_W-1:0];
  assign data_byte   = prev + child[7:0];
  assign rec_byte    = cmd.emit_data ? data_byte : 8'd0;
  assign emitted_inc = emitted + LIMIT_W'(1);
  assign out_free    = !out_valid || out_ready;
  assign push        = pend_valid && (cmd.record || cmd.flush);

  always_comb begin
    sts               = '0;
    sts.hidx_odd      = hidx[0];
    sts.hidx_last     = (hidx == LAST_HEADER);
    sts.in_last       = last_q;
    sts.emit_ge       = (emitted >= limit);
    sts.emit_next_ge  = (emitted_inc >= limit);
    sts.walk_bad      = (walk <= END_NODE) || (walk > TOP_NODE);
    sts.child_ge_walk = (child >= walk);
    sts.child_inner   = (child > END_NODE);
    sts.child_end     = (child == END_NODE);
    sts.bit_zero      = (bit_idx == 3'd0);
    sts.scan_at_end   = (scan_idx == fresh - NODE_W'(1));
    sts.have_two      = v2;
    sts.fresh_top     = (fresh == TOP_NODE);
    sts.rec_ok        = !pend_valid || out_free;
    sts.pend_valid    = pend_valid;
    sts.out_free      = out_free;
  end

  // Configuration register and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      limit      <= LIMIT_RESET;
      hidx       <= '0;
      hi_byte    <= '0;
      root       <= '0;
      walk       <= '0;
      prev       <= '0;
      emitted    <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      pipe_v     <= 1'b0;
    end else begin
      if (cfg_we) limit <= cfg_wdata;
      if (cmd.hidx_clr) hidx <= '0;
      else if (cmd.hidx_inc) hidx <= hidx + NODE_W'(1);
      if (cmd.head_hi) hi_byte <= byte_q;
      if (cmd.build_init) root <= END_NODE;
      else if (cmd.merge_next) root <= fresh;
      if (cmd.data_start) begin
        walk    <= root;
        prev    <= '0;
        emitted <= '0;
      end else if (cmd.walk_child) begin
        walk <= child;
      end else if (cmd.emit_data) begin
        walk    <= root;
        prev    <= data_byte;
        emitted <= emitted_inc;
      end
      pipe_v <= cmd.scan_issue;
      if (cmd.record) pend_valid <= 1'b1;
      else if (cmd.flush) pend_valid <= 1'b0;
      if (push) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Payload and merge search registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      byte_q <= in_byte;
      last_q <= in_last;
    end
    if (cmd.build_init) fresh <= FIRST_INNER;
    else if (cmd.merge_next) fresh <= fresh + NODE_W'(1);
    if (cmd.bit_load) bit_idx <= 3'd7;
    else if (cmd.bit_dec) bit_idx <= bit_idx - 3'd1;
    if (cmd.scan_init) scan_idx <= '0;
    else if (cmd.scan_issue) scan_idx <= scan_idx + NODE_W'(1);
    pipe_addr <= scan_idx;
    if (cmd.scan_init) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (pipe_v && (w_rdata != '0)) begin
      if (!v1 || (w_rdata < w1)) begin
        m2 <= m1;
        w2 <= w1;
        v2 <= v1;
        m1 <= pipe_addr;
        w1 <= w_rdata;
        v1 <= 1'b1;
      end else if (!v2 || (w_rdata < w2)) begin
        m2 <= pipe_addr;
        w2 <= w_rdata;
        v2 <= 1'b1;
      end
    end
    if (cmd.record) begin
      pend_byte <= rec_byte;
      pend_kind <= cmd.rec_kind;
    end
    if (push) begin
      out_byte <= pend_byte;
      out_kind <= pend_kind;
      out_last <= cmd.flush;
    end
  end

endmodule

[hdl/huffman_delta_byte_decoder.sv]
// Top level of the static Huffman decoder with byte delta.
//
// The block takes a compressed stream one byte per beat. The first 512 beats
// carry 256 big-endian 16-bit symbol counts. After the final header byte the
// block builds the code tree in place before it takes the next beat: each
// merge sets up a scan, scans every node below the next free node through the
// weight store's single read port, one node per cycle, and writes the merged
// node; a full build has 256 merges. Each step of the code walk down the tree
// waits on one registered read of the child store; results are held in a
// one-deep staging register and a one-deep output register, and the walk
// pauses only while the output side is stalled and both are full. Each result
// beat carries a kind (data, done or error); every done or error result closes
// the stream, and tlast marks the final result caused by one input beat. After
// done or error the block drops input beats until one with tlast has passed.
// The user writes the output limit through cfg_we/cfg_wdata only while the
// block is idle; the block itself does not enforce this.
module huffman_delta_byte_decoder (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,  // [7:0] in_byte
  input  logic                        s_axis_tlast,  // in_last
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [7:0]                  m_axis_tdata,  // [7:0] out_byte
  output logic [1:0]                  m_axis_tuser,  // [1:0] out_kind
  output logic                        m_axis_tlast,  // out_last
  input  logic                        cfg_we,
  input  logic [hdb_pkg::LIMIT_W-1:0] cfg_wdata      // output_limit
);
  import hdb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The controller owns the stream phase and sequencing.
  hdb_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  // The datapath holds the stores, the walk state and the result registers.
  hdb_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_byte   (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_byte  (m_axis_tdata),
    .out_kind  (m_axis_tuser),
    .out_last  (m_axis_tlast),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

endmodule

[hdl/hdb_checker.sv]
// Port-level checker for the decoder, bound to the top level.
`include "huffman_delta_byte_decoder_defines.svh"

module hdb_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic [7:0]                  s_axis_tdata,
  input logic                        s_axis_tlast,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [7:0]                  m_axis_tdata,
  input logic [1:0]                  m_axis_tuser,
  input logic                        m_axis_tlast,
  input logic                        cfg_we,
  input logic [hdb_pkg::LIMIT_W-1:0] cfg_wdata
);
  import hdb_pkg::*;

  `HDB_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast),
    "result beat changed while stalled")
  `HDB_ASSERT_NOW(a_stop_closes, m_axis_tvalid && (m_axis_tuser != KIND_DATA),
    m_axis_tlast && (m_axis_tdata == 8'd0), "done or error beat not final or not zero")
  `HDB_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready,
    !s_axis_tready, "input taken while previous beat still in work")
  `HDB_ASSERT_NOW(a_busy_mid_item, m_axis_tvalid && !m_axis_tlast,
    !s_axis_tready, "ready raised before all results of a beat were staged")

endmodule

bind huffman_delta_byte_decoder hdb_checker u_hdb_checker (.*);

[dv/tb_huffman_delta_byte_decoder.sv]
// Self-checking testbench for the Huffman delta byte decoder.
module tb_huffman_delta_byte_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import hdb_pkg::*;

  // One decoded result as it should appear on the master side.
  typedef struct {
    logic [7:0] data;
    logic [1:0] kind;
    logic       tl;
  } result_t;

  // One compressed byte waiting to be sent.
  typedef struct {
    logic [7:0] data;
    logic       tl;
  } beat_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = '0;   // [7:0] in_byte
  logic                s_axis_tlast = 1'b0; // in_last
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;        // [7:0] out_byte
  logic [1:0]          m_axis_tuser;        // [1:0] out_kind
  logic                m_axis_tlast;        // out_last
  logic                cfg_we = 1'b0;
  logic [LIMIT_W-1:0]  cfg_wdata = '0;

  huffman_delta_byte_decoder u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  // Clock with an 8 ns period.
  initial begin
    forever #4 clk = ~clk;
  end

  // Compressed bytes still to be sent, and decoded results still awaited.
  beat_t   pending_beats[$];
  result_t awaited_results[$];

  // Idle percentages for sender and receiver.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // Bookkeeping for the summary and the verdict.
  int unsigned mismatches  = 0;
  int unsigned beats_in    = 0;
  int unsigned results_out = 0;
  int unsigned data_seen   = 0;
  int unsigned done_seen   = 0;
  int unsigned error_seen  = 0;
  int unsigned streams     = 0;
  int unsigned quiet_cycles = 0;
  bit          sent_last_edge = 1'b0;

  localparam int unsigned QUIET_LIMIT = 600000;

  // Shadow of the decoder state, kept in step with every accepted beat.
  logic [COUNT_W-1:0] weight_sh [WEIGHT_DEPTH];
  logic [CHILD_W-1:0] kids_sh   [CHILD_DEPTH];
  logic [1:0]         stage_sh;
  logic [NODE_W-1:0]  hdr_pos_sh;
  logic [7:0]         hi_byte_sh;
  logic [NODE_W-1:0]  root_sh;
  logic [NODE_W-1:0]  walk_sh;
  logic [7:0]         prev_sh;
  logic [LIMIT_W-1:0] emitted_sh;
  logic [LIMIT_W-1:0] limit_sh;

  // Merges the two lightest live nodes again and again; ties go to the
  // lower index, and a node whose sum wraps to zero drops out.
  function automatic void build_code_tree();
    int   m1, m2, top;
    bit   v1, v2, merged;
    logic [COUNT_W-1:0] c;
    top = 2 * SYMBOLS;
    merged = 1'b0;
    for (int i = SYMBOLS + 1; i < WEIGHT_DEPTH; i++) weight_sh[i] = '0;
    weight_sh[SYMBOLS] = 16'd1;
    root_sh = END_NODE;
    for (int fresh = SYMBOLS + 1; fresh <= top; fresh++) begin
      m1 = 0; m2 = 0; v1 = 1'b0; v2 = 1'b0;
      for (int i = 0; i <= top; i++) begin
        c = weight_sh[i];
        if (c == 0) continue;
        if (!v1 || c < weight_sh[m1]) begin
          m2 = m1; v2 = v1;
          m1 = i;  v1 = 1'b1;
        end else if (!v2 || c < weight_sh[m2]) begin
          m2 = i; v2 = 1'b1;
        end
      end
      if (!v2) break;
      kids_sh[(fresh - SYMBOLS - 1) & 8'hff] = {NODE_W'(m2), NODE_W'(m1)};
      weight_sh[fresh] = weight_sh[m1] + weight_sh[m2];
      weight_sh[m1] = '0;
      weight_sh[m2] = '0;
      root_sh = NODE_W'(fresh);
      merged = 1'b1;
    end
    if (!merged) root_sh = END_NODE;
  endfunction

  function automatic void add_result(logic [7:0] d, logic [1:0] k);
    result_t r;
    r.data = d;
    r.kind = k;
    r.tl   = 1'b0;
    awaited_results.push_back(r);
  endfunction

  // A done or error closes the stream; with tlast a new header follows.
  function automatic void close_stream(logic [1:0] k, logic lst);
    add_result(8'h00, k);
    stage_sh   = lst ? PH_HEADER : PH_FINISHED;
    hdr_pos_sh = '0;
  endfunction

  // Works out the results that one accepted compressed byte causes.
  function automatic void decode_beat(logic [7:0] b, logic lst);
    int unsigned        before_n;
    bit                 ended;
    logic [CHILD_W-1:0] entry;
    logic [NODE_W-1:0]  child;
    before_n = awaited_results.size();
    ended = 1'b0;
    if (stage_sh == PH_HEADER) begin
      if (!hdr_pos_sh[0])
        hi_byte_sh = b;
      else if ((hdr_pos_sh >> 1) < SYMBOLS)
        weight_sh[hdr_pos_sh >> 1] = {hi_byte_sh, b};
      hdr_pos_sh = hdr_pos_sh + NODE_W'(1);
      if (hdr_pos_sh >= 2 * SYMBOLS) begin
        build_code_tree();
        stage_sh   = PH_DATA;
        walk_sh    = root_sh;
        prev_sh    = '0;
        emitted_sh = '0;
        hdr_pos_sh = '0;
      end
      if (lst) close_stream(KIND_ERROR, 1'b1);
    end else if (stage_sh == PH_DATA) begin
      // A limit that is already reached answers done before any bit.
      if (emitted_sh >= limit_sh) begin
        close_stream(KIND_DONE, lst);
        ended = 1'b1;
      end
      for (int bi = 7; bi >= 0 && !ended; bi--) begin
        if (walk_sh <= END_NODE || walk_sh > TOP_NODE) begin
          close_stream(KIND_ERROR, lst);
          ended = 1'b1;
          break;
        end
        entry = kids_sh[(walk_sh - FIRST_INNER) & 8'hff];
        child = b[bi] ? entry[CHILD_W-1:NODE_W] : entry[NODE_W-1:0];
        if (child >= walk_sh) begin
          close_stream(KIND_ERROR, lst);
          ended = 1'b1;
        end else if (child > END_NODE) begin
          walk_sh = child;
        end else if (child == END_NODE) begin
          close_stream(KIND_DONE, lst);
          ended = 1'b1;
        end else begin
          prev_sh = prev_sh + child[7:0];
          add_result(prev_sh, KIND_DATA);
          emitted_sh = emitted_sh + LIMIT_W'(1);
          walk_sh = root_sh;
          if (emitted_sh >= limit_sh) begin
            close_stream(KIND_DONE, lst);
            ended = 1'b1;
          end
        end
      end
      // The stream ran out before its end symbol or the limit.
      if (!ended && lst) close_stream(KIND_ERROR, 1'b1);
    end else if (lst) begin
      stage_sh   = PH_HEADER;
      hdr_pos_sh = '0;
    end
    if (awaited_results.size() > before_n)
      awaited_results[awaited_results.size() - 1].tl = 1'b1;
  endfunction

  function automatic void queue_beat(logic [7:0] d, logic lst);
    beat_t bt;
    bt.data = d;
    bt.tl   = lst;
    pending_beats.push_back(bt);
  endfunction

  // Queues one stream: a count header then code bytes, the final one
  // carrying tlast. A cut_at below 512 ends the stream inside the header.
  task automatic queue_stream(logic [COUNT_W-1:0] counts[SYMBOLS], int code_len,
                              int cut_at);
    streams++;
    for (int i = 0; i < 2 * SYMBOLS; i++) begin
      if (i == cut_at) begin
        queue_beat(i[0] ? counts[i/2][7:0] : counts[i/2][15:8], 1'b1);
        return;
      end
      queue_beat(i[0] ? counts[i/2][7:0] : counts[i/2][15:8], 1'b0);
    end
    for (int j = 0; j < code_len; j++)
      queue_beat(8'($urandom_range(0, 255)), j == code_len - 1);
  endtask

  // A random stream with a few live symbols; now and then a saturated or
  // wrapping count is mixed in, and once in a while every symbol is live.
  task automatic queue_random_stream(bit full_tree);
    logic [COUNT_W-1:0] counts[SYMBOLS];
    int live;
    foreach (counts[i]) counts[i] = '0;
    if (full_tree) begin
      foreach (counts[i]) counts[i] = 16'($urandom_range(1, 65535));
    end else begin
      live = $urandom_range(1, 10);
      for (int k = 0; k < live; k++) begin
        case ($urandom_range(0, 7))
          0:       counts[$urandom_range(0, SYMBOLS - 1)] = 16'hffff;
          1:       counts[$urandom_range(0, SYMBOLS - 1)] = 16'h8000;
          2:       counts[$urandom_range(0, SYMBOLS - 1)] = 16'($urandom);
          default: counts[$urandom_range(0, SYMBOLS - 1)] = 16'($urandom_range(1, 40));
        endcase
      end
    end
    queue_stream(counts, $urandom_range(4, 30), 2 * SYMBOLS);
  endtask

  // Writes the output limit while the decoder has nothing in flight.
  task automatic write_limit(logic [LIMIT_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    limit_sh  = v;
  endtask

  // Lets the queued stimulus drain, then allows the last byte's walk to
  // settle before anything else is done.
  task automatic drain_all();
    wait (pending_beats.size() == 0 && awaited_results.size() == 0);
    repeat (48) @(posedge clk);
  endtask

  // Sender: presents the head of the queue at the falling edge, holding it
  // until the beat is taken, and idles at random between beats.
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_axis_tvalid || sent_last_edge) begin
        if (pending_beats.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_beats[0].data;
          s_axis_tlast  <= pending_beats[0].tl;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Monitor: takes accepted input beats into the shadow model and checks
  // every accepted result beat against the oldest awaited result.
  always @(posedge clk) begin
    result_t want;
    bit      moved;
    moved = 1'b0;
    sent_last_edge = 1'b0;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        decode_beat(s_axis_tdata, s_axis_tlast);
        void'(pending_beats.pop_front());
        sent_last_edge = 1'b1;
        beats_in++;
        moved = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        moved = 1'b1;
        results_out++;
        case (m_axis_tuser)
          KIND_DATA: data_seen++;
          KIND_DONE: done_seen++;
          default:   error_seen++;
        endcase
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result beat with nothing awaited: byte %02h kind %0d last %0b",
                     $realtime, m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end else begin
          want = awaited_results.pop_front();
          if (m_axis_tdata !== want.data || m_axis_tuser !== want.kind ||
              m_axis_tlast !== want.tl) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: result mismatch: expected byte %02h kind %0d last %0b,",
                       $realtime, want.data, want.kind, want.tl,
                       " got byte %02h kind %0d last %0b",
                       m_axis_tdata, m_axis_tuser, m_axis_tlast);
          end
        end
      end
      // Watchdog: counts cycles in which neither side moves a beat.
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("huffman_delta_byte_decoder verification failed");
        $finish;
      end
    end
  end

  // Stimulus sequence: reset, a directed set of streams, then random phases
  // with different limits and idle patterns.
  initial begin
    logic [COUNT_W-1:0] counts[SYMBOLS];

    foreach (weight_sh[i]) weight_sh[i] = '0;
    foreach (kids_sh[i]) kids_sh[i] = '0;
    stage_sh = PH_HEADER; hdr_pos_sh = '0; hi_byte_sh = '0; root_sh = '0;
    walk_sh = '0; prev_sh = '0; emitted_sh = '0; limit_sh = LIMIT_RESET;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed streams at the reset limit, under the first idle pattern.
    send_idle_pct = 26;
    recv_idle_pct = 61;
    // A single live symbol of saturated count: the end code is one bit deep.
    foreach (counts[i]) counts[i] = '0;
    counts[255] = 16'hffff;
    queue_stream(counts, 6, 2 * SYMBOLS);
    // Two counts of 0x8000 beside lighter counts: the final merge's sum wraps.
    foreach (counts[i]) counts[i] = '0;
    counts[0] = 16'h8000; counts[1] = 16'h8000; counts[170] = 16'd3;
    queue_stream(counts, 6, 2 * SYMBOLS);
    // No live symbol at all: the root is the end leaf and code errors out.
    foreach (counts[i]) counts[i] = '0;
    queue_stream(counts, 3, 2 * SYMBOLS);
    // Stream cut short inside the header, on the very last header byte.
    foreach (counts[i]) counts[i] = 16'h5aa5;
    queue_stream(counts, 0, 2 * SYMBOLS - 1);
    // Equal counts so that ties decide the shape of the tree.
    foreach (counts[i]) counts[i] = '0;
    counts[7] = 16'd2; counts[8] = 16'd2; counts[9] = 16'd2; counts[128] = 16'd1;
    queue_stream(counts, 5, 2 * SYMBOLS);
    drain_all();

    // Random phases. The drain at each boundary waits for every
    // awaited result before the next limit is written.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin send_idle_pct = 26; recv_idle_pct = 61; end
        1: begin send_idle_pct = 61; recv_idle_pct = 26; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      case (ph)
        0: write_limit(24'd0);
        1: write_limit(24'd1);
        2: write_limit(24'd3);
        3: write_limit(24'($urandom_range(5, 40)));
        4: write_limit(24'hffffff);
        default: write_limit(LIMIT_RESET);
      endcase
      for (int s = 0; s < 2; s++) queue_random_stream(ph == 4 && s == 0);
      // A stream abandoned somewhere in its header.
      if (ph == 3) begin
        foreach (counts[i]) counts[i] = 16'($urandom);
        queue_stream(counts, 0, $urandom_range(0, 2 * SYMBOLS - 2));
      end
      drain_all();
    end

    if (awaited_results.size() != 0) mismatches++;
    $display("Sent %0d streams in %0d beats; received %0d results",
             streams, beats_in, results_out,
             " (%0d data, %0d done, %0d error).", data_seen, done_seen, error_seen);
    $display("Limits from zero to full scale were used under three idle patterns.");
    if (mismatches == 0) begin
      $display("huffman_delta_byte_decoder verification clean");
    end else begin
      $display("huffman_delta_byte_decoder verification failed");
    end
    $finish;
  end

endmodule
